### design/mavg_pkg.sv
// Shared constants for the moving average filter.
// Field widths, register reset value and the default history depth.
// No dependencies.
package mavg_pkg;

  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned WLEN_W        = 8;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 8'd16;
  localparam int unsigned DEPTH_DEFAULT = 16;

endpackage

### design/mavg_div.sv
// Restoring divider for the moving average filter: one quotient bit per cycle.
// Depends on mavg_pkg for the result width.
module mavg_div #(
  parameter int unsigned SUM_W = 21,
  parameter int unsigned LEN_W = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [SUM_W-1:0]              dividend,
  input  logic [LEN_W-1:0]              divisor,
  output logic                          done,
  output logic [mavg_pkg::SAMPLE_W-1:0] quotient
);

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quot;
  logic [LEN_W-1:0]  rem;
  logic [LEN_W-1:0]  dsor;
  logic [STEP_W-1:0] steps;
  logic              busy;

  logic [LEN_W:0] trial;
  logic [LEN_W:0] diff;
  logic           fits;

  assign trial = {rem, quot[SUM_W-1]};
  assign fits  = (trial >= {1'b0, dsor});
  assign diff  = trial - {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dsor <= divisor;
    end else if (busy) begin
      // shift in the next dividend bit, subtract when the divisor fits
      quot <= {quot[SUM_W-2:0], fits};
      rem  <= fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
    end
  end

  // quotient never exceeds the largest sample, so the low bits are the result
  assign quotient = quot[mavg_pkg::SAMPLE_W-1:0];

endmodule

### design/moving_average_filter_core.sv
// Moving average filter top level: circular history memory, summing sequencer.
// Depends on mavg_pkg and mavg_div.
//
// Usage:
//   Input channel in_valid/in_ready/sample carries one request per sample.
//   Output channel out_valid/out_ready/average returns exactly one average
//   per request, in order. cfg_wr_en/cfg_wr_data write the window length
//   (clamped to 1..DEPTH when used); write it only while the block is idle.
//   Each request writes the sample at the write pointer, then reads history
//   entries 0..len-1 one per cycle through the memory read port and adds them,
//   then divides the sum by len in a bit-serial divider (one bit per cycle).
//   One request is processed at a time: a new request is taken only once
//   the previous one has gone through the summing and divide steps.
//   in_ready rises again as soon as the result is in the output register,
//   so the next request is taken while a result still waits for out_ready.
//   If the receiver stalls, the finished quotient holds until the output
//   register frees up.
//   Reset (rst, synchronous) clears the history through per-entry valid bits,
//   zeroes the write pointer and sets the window length to 16.
module moving_average_filter_core #(
  parameter int unsigned DEPTH = mavg_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mavg_pkg::SAMPLE_W-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mavg_pkg::SAMPLE_W-1:0] average,
  input  logic                          cfg_wr_en,
  input  logic [mavg_pkg::WLEN_W-1:0]   cfg_wr_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LEN_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = mavg_pkg::SAMPLE_W + LEN_W;
  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [mavg_pkg::WLEN_W-1:0]   wlen;
  logic [LEN_W-1:0]              len_clamped;
  logic [LEN_W-1:0]              len;
  logic [PTR_W-1:0]              wp;
  logic [LEN_W-1:0]              wp_inc;
  logic [LEN_W-1:0]              cnt;
  logic                          rd_en;
  logic                          pend;
  logic [mavg_pkg::SAMPLE_W-1:0] rdata;
  logic                          rvld;
  logic [SUM_W-1:0]              sum;
  logic                          accept;
  logic                          div_start;
  logic                          div_done;
  logic [mavg_pkg::SAMPLE_W-1:0] div_q;
  logic                          out_free;

  logic [mavg_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]              written;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign rd_en     = (state == ST_SUM) && (cnt != len);
  assign div_start = (state == ST_SUM) && !rd_en && !pend;
  assign out_free  = !out_valid || out_ready;
  assign wp_inc    = LEN_W'(wp) + 1'b1;

  always_comb begin
    if (wlen == '0) begin
      len_clamped = LEN_W'(1);
    end else if (32'(wlen) > DEPTH) begin
      len_clamped = DEPTH_L;
    end else begin
      len_clamped = LEN_W'(wlen);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_SUM;
      end
      ST_SUM: begin
        if (div_start) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wlen      <= mavg_pkg::WLEN_RESET;
      wp        <= '0;
      written   <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) wlen <= cfg_wr_data;
      if (accept) begin
        written[wp] <= 1'b1;
        // wrap once the pointer reaches the window length
        wp <= (wp_inc >= len_clamped) ? '0 : wp_inc[PTR_W-1:0];
      end
      pend <= rd_en;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // history memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept) mem[wp] <= sample;
    if (rd_en) begin
      rdata <= mem[cnt[PTR_W-1:0]];
      rvld  <= written[cnt[PTR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      len <= len_clamped;
      cnt <= '0;
      sum <= '0;
    end else begin
      if (rd_en) cnt <= cnt + 1'b1;
      // entries never written since reset count as zero
      if (pend && rvld) sum <= sum + SUM_W'(rdata);
    end
    if (state == ST_DONE && out_free) average <= div_q;
  end

  mavg_div #(
    .SUM_W (SUM_W),
    .LEN_W (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (len),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

### tb/moving_average_filter_core_tb.sv
// Self-checking testbench for moving_average_filter_core: directed and random samples,
// window-length sweeps and random stalls on both channels, checked against a local predictor.
// Depends on mavg_pkg and the moving_average_filter_core RTL.
module moving_average_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAMPLE_W  = mavg_pkg::SAMPLE_W;
  localparam int unsigned WLEN_W    = mavg_pkg::WLEN_W;
  localparam int unsigned DEPTH     = mavg_pkg::DEPTH_DEFAULT;
  localparam int unsigned ITEMS     = 1400;
  localparam int unsigned SETTLE    = DEPTH + 16 + 5 + 20;
  localparam logic [WLEN_W-1:0] WLEN_ZERO = '0;
  localparam logic [WLEN_W-1:0] WLEN_MAX  = '1;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] sample      = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic [SAMPLE_W-1:0] average;
  logic                cfg_wr_en   = 1'b0;
  logic [WLEN_W-1:0]   cfg_wr_data = '0;

  // predictor state
  logic [SAMPLE_W-1:0] model_hist [DEPTH];
  int unsigned         model_ptr;
  logic [WLEN_W-1:0]   model_wlen;

  logic [SAMPLE_W-1:0] pending_averages [$];
  int unsigned         mismatch_cnt = 0;
  int unsigned         sent_cnt     = 0;
  int unsigned         stall_cnt    = 0;
  bit                  no_idle      = 1'b0;

  moving_average_filter_core #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .average    (average),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  initial begin
    #10ms;
    $display("moving_average_filter_core_tb failed");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return SAMPLE_W'($urandom_range(0, 15));
      3: return SAMPLE_W'(65535 - $urandom_range(0, 15));
      default: return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [WLEN_W-1:0] pick_window();
    case ($urandom_range(0, 9))
      0: return WLEN_ZERO;
      1: return WLEN_W'(1);
      2: return WLEN_W'(DEPTH);
      3: return WLEN_MAX;
      4: return WLEN_W'($urandom_range(DEPTH + 1, 254));
      default: return WLEN_W'($urandom_range(2, DEPTH - 1));
    endcase
  endfunction

  // Store the sample, advance the pointer and return the floor of the window mean.
  function automatic logic [SAMPLE_W-1:0] advance_window_average(input logic [SAMPLE_W-1:0] s);
    int unsigned len;
    logic [31:0] total;
    len = (model_wlen == 0) ? 1 : ((model_wlen > DEPTH) ? DEPTH : model_wlen);
    model_hist[model_ptr] = s;
    model_ptr++;
    if (model_ptr >= len) begin
      model_ptr = 0;
    end
    total = '0;
    for (int unsigned i = 0; i < len; i++) begin
      total += model_hist[i];
    end
    return SAMPLE_W'(total / len);
  endfunction

  // Called right after a rising edge; returns right after the edge that takes the request.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_averages.push_back(advance_window_average(s));
    sent_cnt++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_window(input logic [WLEN_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    model_wlen = v;
  endtask

  // Reset window of sixteen: early averages include the cleared history.
  task automatic test_reset_history();
    send_sample('1);
    send_sample('1);
    send_sample('0);
    send_sample(16'h8000);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    wait_drained();
  endtask

  task automatic test_window_clamp();
    write_window(WLEN_ZERO);
    send_sample('1);
    send_sample(16'h1234);
    wait_drained();
    write_window(WLEN_MAX);
    send_sample('1);
    wait_drained();
    write_window(WLEN_W'(DEPTH + 1));
    send_sample(16'h0001);
    wait_drained();
    write_window(WLEN_W'(1));
    send_sample(16'hFFFE);
    wait_drained();
  endtask

  // Shrink the window below the pointer, then grow it to expose the stranded entry.
  task automatic test_window_shrink();
    write_window(WLEN_W'(DEPTH));
    for (int i = 0; i < 9; i++) begin
      send_sample(pick_sample());
    end
    wait_drained();
    write_window(WLEN_W'(3));
    send_sample(16'hBEEF);
    send_sample(16'h0F0F);
    wait_drained();
    write_window(WLEN_W'(DEPTH));
    send_sample(16'h7FFF);
    wait_drained();
  endtask

  // Hold each request until the previous average has been taken.
  task automatic test_drain_between_requests();
    write_window(WLEN_W'($urandom_range(2, DEPTH)));
    for (int i = 0; i < 20; i++) begin
      send_sample(pick_sample());
      wait_drained();
    end
  endtask

  task automatic test_random_windows();
    int unsigned burst;
    while (sent_cnt < ITEMS) begin
      write_window(pick_window());
      no_idle = ($urandom_range(0, 4) == 0);
      burst = $urandom_range(20, 80);
      for (int unsigned i = 0; i < burst; i++) begin
        send_sample(pick_sample());
      end
      wait_drained();
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_cnt != 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      stall_cnt <= pick_gap();
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_average
    logic [SAMPLE_W-1:0] want;
    if (rst === 1'b0 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_averages.size() == 0) begin
        $display("%0t: unexpected average, expected none, actual %0d", $time, average);
        mismatch_cnt++;
      end else begin
        want = pending_averages.pop_front();
        if (average !== want) begin
          $display("%0t: average mismatch, expected %0d, actual %0d", $time, want, average);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      model_hist[i] = '0;
    end
    model_ptr  = 0;
    model_wlen = mavg_pkg::WLEN_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_history();
    test_window_clamp();
    test_window_shrink();
    test_drain_between_requests();
    test_random_windows();

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_cnt == 0 && pending_averages.size() == 0) begin
      $display("moving_average_filter_core_tb passed");
    end else begin
      $display("moving_average_filter_core_tb failed");
    end
    $finish;
  end

endmodule
